// ----- rtl/qml_pkg.sv -----
package qml_pkg;

    // lattice defaults
    localparam int CELLS_ACROSS_DEF = 128;
    localparam int ROWS_DEF         = 128;
    localparam int FRAME_WIDTH_DEF  = 256;

    // field widths of the channels
    localparam int ACT_W      = 2;
    localparam int COORD_W    = 7;
    localparam int COORD_N    = 2 ** COORD_W;
    localparam int VALUE_W    = 17;
    localparam int BYTE_W     = 8;
    localparam int COL_W      = 8;
    localparam int ROW_W      = 7;

    // action codes
    localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SWAP   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_IDLE   = 2'd3;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 2'd1;
    localparam int BRAIN_W    = 5;
    localparam int SPEED_W    = 12;

    // quadratic map constants
    localparam int MULT_BASE     = 408;
    localparam int MULT_W        = 9;
    localparam int QMAP_TOP      = 65535;
    localparam int QMAP_W        = 16;
    localparam int CENTER_WEIGHT = 10;
    localparam int SHIFT_PROD    = 8;
    localparam int SHIFT_MULT    = 7;
    localparam int SHIFT_MAP     = 6;
    localparam int SHIFT_SUM     = 4;
    localparam int SPEED_SHIFT   = 2;

    // queues
    localparam int CMD_DEPTH = 4;
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
    localparam int OUT_DEPTH = 8;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic [VALUE_W-1:0] new_value;
        logic [BYTE_W-1:0]  pixel_byte;
        logic [COL_W-1:0]   left_column;
        logic [COL_W-1:0]   mirror_column;
        logic [ROW_W-1:0]   pixel_row;
    } t_result;

    // selector bits are rotated before they are added to the base
    function automatic logic [MULT_W-1:0] brain_mult(input logic [BRAIN_W-1:0] m);
        return MULT_W'(MULT_BASE) + MULT_W'({m[1:0], m[BRAIN_W-1:2]});
    endfunction

endpackage

// ----- rtl/qml_if.sv -----
interface qml_in_if;
    logic                          valid;
    logic                          ready;
    logic [qml_pkg::ACT_W-1:0]     action;
    logic [qml_pkg::COORD_W-1:0]   cell_x;
    logic [qml_pkg::COORD_W-1:0]   cell_y;
    logic [qml_pkg::VALUE_W-1:0]   load_value;

    modport source (output valid, action, cell_x, cell_y, load_value, input ready);
    modport sink   (input valid, action, cell_x, cell_y, load_value, output ready);
endinterface

interface qml_out_if;
    logic                          valid;
    logic                          ready;
    logic [qml_pkg::VALUE_W-1:0]   new_value;
    logic [qml_pkg::BYTE_W-1:0]    pixel_byte;
    logic [qml_pkg::COL_W-1:0]     left_column;
    logic [qml_pkg::COL_W-1:0]     mirror_column;
    logic [qml_pkg::ROW_W-1:0]     pixel_row;

    modport source (output valid, new_value, pixel_byte, left_column, mirror_column,
                     pixel_row, input ready);
    modport sink   (input valid, new_value, pixel_byte, left_column, mirror_column,
                     pixel_row, output ready);
endinterface

interface qml_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [qml_pkg::CFG_IDX_W-1:0]    index;
    logic [qml_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/qml_ram.sv -----
module qml_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // reads return the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

// ----- rtl/qml_fifo.sv -----
module qml_fifo #(
    parameter type t_entry = logic,
    parameter int  DEPTH   = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  t_entry                     i_data,
    input  logic                       i_pop,
    output t_entry                     o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic [AW-1:0]   n_wr;
    logic [AW-1:0]   n_rd;
    logic [CW-1:0]   n_cnt;

    // callers never push when full or pop when empty
    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_count = r_cnt;

endmodule

// ----- rtl/qml_front.sv -----
module qml_front #(
    parameter int  CELLS_ACROSS = qml_pkg::CELLS_ACROSS_DEF,
    parameter int  ROWS         = qml_pkg::ROWS_DEF,
    parameter int  FRAME_WIDTH  = qml_pkg::FRAME_WIDTH_DEF,
    parameter type t_cmd        = logic
) (
    qml_in_if.sink                        i_in,
    input  logic [qml_pkg::CMD_CNT_W-1:0] i_cmd_count,
    output logic                          o_push,
    output t_cmd                          o_cmd
);

    localparam int XW = $clog2(CELLS_ACROSS);
    localparam int YW = $clog2(ROWS);

    logic [XW-1:0]               x_tab [qml_pkg::COORD_N];
    logic [YW-1:0]               y_tab [qml_pkg::COORD_N];
    logic [XW-1:0]               x;
    logic [YW-1:0]               y;
    logic [qml_pkg::ACT_W-1:0]   kind;

    // coordinate reduction tables, filled at elaboration
    for (genvar v = 0; v < qml_pkg::COORD_N; v++) begin : g_tab
        assign x_tab[v] = XW'(v % CELLS_ACROSS);
        assign y_tab[v] = YW'(v % ROWS);
    end

    assign x = x_tab[i_in.cell_x];
    assign y = y_tab[i_in.cell_y];

    always_comb begin
        case (i_in.action)
            qml_pkg::ACT_LOAD:   kind = qml_pkg::ACT_LOAD;
            qml_pkg::ACT_UPDATE: kind = qml_pkg::ACT_UPDATE;
            qml_pkg::ACT_SWAP:   kind = qml_pkg::ACT_SWAP;
            default:             kind = qml_pkg::ACT_IDLE;
        endcase
    end

    assign i_in.ready = (i_cmd_count < qml_pkg::CMD_CNT_W'(qml_pkg::CMD_DEPTH));
    assign o_push     = i_in.valid && i_in.ready;

    always_comb begin
        o_cmd            = '0;
        o_cmd.kind       = kind;
        o_cmd.x          = x;
        o_cmd.y          = y;
        // torus neighbours
        o_cmd.xl         = (x == '0) ? XW'(CELLS_ACROSS - 1) : x - XW'(1);
        o_cmd.xr         = (x == XW'(CELLS_ACROSS - 1)) ? '0 : x + XW'(1);
        o_cmd.yu         = (y == '0) ? YW'(ROWS - 1) : y - YW'(1);
        o_cmd.yd         = (y == YW'(ROWS - 1)) ? '0 : y + YW'(1);
        o_cmd.load_value = i_in.load_value;
        o_cmd.left_col   = qml_pkg::COL_W'(x);
        o_cmd.mirror_col = qml_pkg::COL_W'(FRAME_WIDTH - 2) - qml_pkg::COL_W'(x);
        o_cmd.row        = qml_pkg::ROW_W'(y);
    end

endmodule

// ----- rtl/qml_back.sv -----
module qml_back #(
    parameter int  CELLS_ACROSS = qml_pkg::CELLS_ACROSS_DEF,
    parameter int  ROWS         = qml_pkg::ROWS_DEF,
    parameter type t_cmd        = logic
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_pop,
    input  logic [qml_pkg::BRAIN_W-1:0]   i_brain_select,
    input  logic [qml_pkg::SPEED_W-1:0]   i_speed_raw,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output qml_pkg::t_result              o_res
);

    localparam int XW    = $clog2(CELLS_ACROSS);
    localparam int YW    = $clog2(ROWS);
    localparam int AW    = 1 + YW + XW;
    localparam int VW    = qml_pkg::VALUE_W;
    localparam int P1_W  = 2 * VW + 1;
    localparam int T1_W  = P1_W - qml_pkg::SHIFT_PROD;
    localparam int MW    = qml_pkg::MULT_W + 1;
    localparam int P2_W  = T1_W + MW;
    localparam int Q_LO  = qml_pkg::SHIFT_MULT + qml_pkg::SHIFT_MAP;
    localparam int QW    = qml_pkg::QMAP_W;
    localparam int ACC_W = VW + 3;
    localparam int SUM_W = VW + 4;
    localparam int SPW   = qml_pkg::SPEED_W - qml_pkg::SPEED_SHIFT;

    typedef struct packed {
        logic                        upd;
        logic                        board;
        logic [XW-1:0]               x;
        logic [XW-1:0]               xr;
        logic [YW-1:0]               y;
        logic [YW-1:0]               yu;
        logic [YW-1:0]               yd;
        logic [qml_pkg::COL_W-1:0]   left_col;
        logic [qml_pkg::COL_W-1:0]   mirror_col;
        logic [qml_pkg::ROW_W-1:0]   row;
    } t_slot;

    logic                            r_cur;
    logic [3:0]                      r_v;
    t_slot                           r_slot [4];
    t_slot                           n_slot;

    logic                            rd_busy;
    logic                            wr_busy;
    logic                            upd_any;
    logic                            kind_ok;
    logic                            room;
    logic                            issue;

    logic                            we;
    logic [AW-1:0]                   waddr;
    logic [VW-1:0]                   wdata;
    logic [AW-1:0]                   raddr0;
    logic [AW-1:0]                   raddr1;
    logic [VW-1:0]                   rd0;
    logic [VW-1:0]                   rd1;

    logic [qml_pkg::MULT_W-1:0]      mult;
    logic [VW-2:0]                   c_half;
    logic signed [VW:0]              c_diff;
    logic signed [P1_W-1:0]          p1;
    logic signed [T1_W-1:0]          r_t1;
    logic [VW-1:0]                   r_l;
    logic signed [P2_W-1:0]          p2;
    logic [QW-1:0]                   r_q;
    logic [ACC_W-1:0]                acc;
    logic [ACC_W-1:0]                r_acc;
    logic [SUM_W-1:0]                sum;
    logic [VW-1:0]                   r_res;

    logic [qml_pkg::OUT_CNT_W-1:0]   out_count;
    qml_pkg::t_result                out_data;

    // ---------------- issue ----------------
    assign rd_busy = (r_v[0] && r_slot[0].upd) || (r_v[1] && r_slot[1].upd);
    assign wr_busy = r_v[3] && r_slot[3].upd;
    assign upd_any = rd_busy || wr_busy || (r_v[2] && r_slot[2].upd);
    assign room    = (int'(out_count) + $countones(r_v)) < qml_pkg::OUT_DEPTH;

    always_comb begin
        case (i_cmd.kind)
            qml_pkg::ACT_UPDATE: kind_ok = !rd_busy;
            // a load issued right after an update would land before its down read
            qml_pkg::ACT_LOAD:   kind_ok = !wr_busy && !(r_v[0] && r_slot[0].upd);
            // pending writes must land before the boards trade roles
            qml_pkg::ACT_SWAP:   kind_ok = !upd_any;
            default:             kind_ok = 1'b1;
        endcase
    end

    assign issue     = i_cmd_valid && room && kind_ok;
    assign o_cmd_pop = issue;

    always_comb begin
        n_slot            = '0;
        n_slot.upd        = (i_cmd.kind == qml_pkg::ACT_UPDATE);
        n_slot.board      = r_cur;
        n_slot.x          = i_cmd.x;
        n_slot.xr         = i_cmd.xr;
        n_slot.y          = i_cmd.y;
        n_slot.yu         = i_cmd.yu;
        n_slot.yd         = i_cmd.yd;
        n_slot.left_col   = i_cmd.left_col;
        n_slot.mirror_col = i_cmd.mirror_col;
        n_slot.row        = i_cmd.row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= 1'b0;
            r_v   <= '0;
        end else begin
            r_v <= {r_v[2:0], issue};
            if (issue && (i_cmd.kind == qml_pkg::ACT_SWAP)) begin
                r_cur <= ~r_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot[0] <= n_slot;
        r_slot[1] <= r_slot[0];
        r_slot[2] <= r_slot[1];
        r_slot[3] <= r_slot[2];
    end

    // ---------------- board memory ----------------
    // center and left at issue, right and up in stage 1, down in stage 2
    always_comb begin
        raddr0 = {r_cur, i_cmd.y, i_cmd.x};
        raddr1 = {r_cur, i_cmd.y, i_cmd.xl};
        if (r_v[0] && r_slot[0].upd) begin
            raddr0 = {r_slot[0].board, r_slot[0].y, r_slot[0].xr};
            raddr1 = {r_slot[0].board, r_slot[0].yu, r_slot[0].x};
        end else if (r_v[1] && r_slot[1].upd) begin
            raddr0 = {r_slot[1].board, r_slot[1].yd, r_slot[1].x};
        end
    end

    always_comb begin
        if (wr_busy) begin
            we    = 1'b1;
            waddr = {~r_slot[3].board, r_slot[3].y, r_slot[3].x};
            wdata = r_res;
        end else begin
            we    = issue && (i_cmd.kind == qml_pkg::ACT_LOAD);
            waddr = {r_cur, i_cmd.y, i_cmd.x};
            wdata = i_cmd.load_value;
        end
    end

    qml_ram #(
        .WIDTH (VW),
        .DEPTH (2 ** AW)
    ) u_board (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (rd0),
        .o_rdata1 (rd1)
    );

    // ---------------- datapath ----------------
    assign mult   = qml_pkg::brain_mult(i_brain_select);

    // stage 1: (c / 2) * (65535 - c) term, rd0 = center, rd1 = left
    assign c_half = rd0[VW-1:1];
    assign c_diff = $signed((VW+1)'(qml_pkg::QMAP_TOP) - {1'b0, rd0});
    assign p1     = $signed({1'b0, c_half}) * c_diff;

    // stage 2: scale by multiplier, rd0 = right, rd1 = up
    assign p2     = $signed({1'b0, mult}) * r_t1;
    assign acc    = ACC_W'(r_l) + ACC_W'(rd0) + ACC_W'({rd1, 1'b0});

    // stage 3: rd0 = down; the sum never goes negative so no clamp is needed
    assign sum    = SUM_W'(r_q) * SUM_W'(qml_pkg::CENTER_WEIGHT)
                  + SUM_W'(i_speed_raw[qml_pkg::SPEED_W-1:qml_pkg::SPEED_SHIFT])
                  + SUM_W'(r_acc) + SUM_W'({rd0, 1'b0});

    always_ff @(posedge i_clk) begin
        r_t1  <= p1[P1_W-1:qml_pkg::SHIFT_PROD];
        r_l   <= rd1;
        r_q   <= p2[Q_LO+QW-1:Q_LO];
        r_acc <= acc;
        r_res <= sum[qml_pkg::SHIFT_SUM+VW-1:qml_pkg::SHIFT_SUM];
    end

    // ---------------- result queue ----------------
    always_comb begin
        out_data = '0;
        if (r_slot[3].upd) begin
            out_data.new_value     = r_res;
            out_data.pixel_byte    = r_res[qml_pkg::BYTE_W-1:0];
            out_data.left_column   = r_slot[3].left_col;
            out_data.mirror_column = r_slot[3].mirror_col;
            out_data.pixel_row     = r_slot[3].row;
        end
    end

    assign o_res_valid = (out_count != '0);

    qml_fifo #(
        .t_entry (qml_pkg::t_result),
        .DEPTH   (qml_pkg::OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_v[3]),
        .i_data  (out_data),
        .i_pop   (o_res_valid && i_res_ready),
        .o_data  (o_res),
        .o_count (out_count)
    );

endmodule

// ----- rtl/quadratic_map_lattice_step.sv -----
// channel   dir   handshake          payload
// i_in      in    valid/ready        action, cell_x, cell_y, load_value
// o_out     out   valid/ready        new_value, pixel_byte, left_column, mirror_column,
//                                    pixel_row
// i_cfg     in    valid/ready        index, data (ready always high)
//
// an update reads the board memory five times, on both ports at issue and in stage 1 and
// on one in stage 2, so a new update waits until the previous one is past stage 2; loads and unused
// actions issue every cycle while the result queue has room, except that a load waits out
// the cycle right after an update issues and while one writes its cell; a swap waits until
// every update in flight has written its cell. every issued item yields a result.
// reset clears board select, configuration and queues; board memory is not cleared.
// either side may stall: a 4-entry command queue and an 8-entry result queue decouple them.
module quadratic_map_lattice_step #(
    parameter int CELLS_ACROSS = qml_pkg::CELLS_ACROSS_DEF,
    parameter int ROWS         = qml_pkg::ROWS_DEF,
    parameter int FRAME_WIDTH  = qml_pkg::FRAME_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qml_in_if.sink     i_in,
    qml_out_if.source  o_out,
    qml_cfg_if.sink    i_cfg
);

    localparam int XW = $clog2(CELLS_ACROSS);
    localparam int YW = $clog2(ROWS);

    typedef struct packed {
        logic [qml_pkg::ACT_W-1:0]   kind;
        logic [XW-1:0]               x;
        logic [XW-1:0]               xl;
        logic [XW-1:0]               xr;
        logic [YW-1:0]               y;
        logic [YW-1:0]               yu;
        logic [YW-1:0]               yd;
        logic [qml_pkg::VALUE_W-1:0] load_value;
        logic [qml_pkg::COL_W-1:0]   left_col;
        logic [qml_pkg::COL_W-1:0]   mirror_col;
        logic [qml_pkg::ROW_W-1:0]   row;
    } t_cmd;

    logic [qml_pkg::BRAIN_W-1:0]     r_brain;
    logic [qml_pkg::SPEED_W-1:0]     r_speed;

    logic                            cmd_push;
    t_cmd                            cmd_in;
    t_cmd                            cmd_head;
    logic                            cmd_pop;
    logic [qml_pkg::CMD_CNT_W-1:0]   cmd_count;

    logic                            res_valid;
    qml_pkg::t_result                res;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brain <= '0;
            r_speed <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                qml_pkg::CFG_BRAIN: r_brain <= i_cfg.data[qml_pkg::BRAIN_W-1:0];
                qml_pkg::CFG_SPEED: r_speed <= i_cfg.data[qml_pkg::SPEED_W-1:0];
                default:            ;
            endcase
        end
    end

    qml_front #(
        .CELLS_ACROSS (CELLS_ACROSS),
        .ROWS         (ROWS),
        .FRAME_WIDTH  (FRAME_WIDTH),
        .t_cmd        (t_cmd)
    ) u_front (
        .i_in        (i_in),
        .i_cmd_count (cmd_count),
        .o_push      (cmd_push),
        .o_cmd       (cmd_in)
    );

    qml_fifo #(
        .t_entry (t_cmd),
        .DEPTH   (qml_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head),
        .o_count (cmd_count)
    );

    qml_back #(
        .CELLS_ACROSS (CELLS_ACROSS),
        .ROWS         (ROWS),
        .t_cmd        (t_cmd)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd_head),
        .i_cmd_valid    (cmd_count != '0),
        .o_cmd_pop      (cmd_pop),
        .i_brain_select (r_brain),
        .i_speed_raw    (r_speed),
        .o_res_valid    (res_valid),
        .i_res_ready    (o_out.ready),
        .o_res          (res)
    );

    assign o_out.valid         = res_valid;
    assign o_out.new_value     = res.new_value;
    assign o_out.pixel_byte    = res.pixel_byte;
    assign o_out.left_column   = res.left_column;
    assign o_out.mirror_column = res.mirror_column;
    assign o_out.pixel_row     = res.pixel_row;

endmodule

// ----- rtl/qml_checker.sv -----
module qml_checker #(
    parameter int FRAME_WIDTH = qml_pkg::FRAME_WIDTH_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    qml_out_if.source  o_out
);

    localparam logic [qml_pkg::COL_W-1:0] MIRROR_BASE = qml_pkg::COL_W'(FRAME_WIDTH - 2);

    // result queue comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.new_value)
            && $stable(o_out.mirror_column) && $stable(o_out.pixel_row))
        else $error("stalled result changed");

    // pixel byte always tracks the value, zero items included
    a_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.pixel_byte == o_out.new_value[qml_pkg::BYTE_W-1:0])
        else $error("pixel byte does not match new value");

    // an update result places its mirror copy opposite the left copy
    a_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.left_column != '0 || o_out.pixel_row != '0
            || o_out.new_value != '0)
        |-> o_out.mirror_column == MIRROR_BASE - o_out.left_column)
        else $error("mirror column inconsistent with left column");

endmodule

bind quadratic_map_lattice_step qml_checker #(
    .FRAME_WIDTH (FRAME_WIDTH)
) u_qml_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_out   (o_out)
);
